@@ sv/pmr_pkg.sv @@
// Shared types and constants for the palette merge and remap block.
package pmr_pkg;

    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned IDX_W               = 8;
    localparam int unsigned COUNT_W             = 9;
    localparam int unsigned COLOR_W             = 24;
    localparam logic [COLOR_W-1:0] MAGENTA      = 24'hFF00FF;

    localparam logic [2:0] REQ_CLEAR = 3'd0;
    localparam logic [2:0] REQ_MERGE = 3'd1;
    localparam logic [2:0] REQ_LOAD  = 3'd2;
    localparam logic [2:0] REQ_START = 3'd3;
    localparam logic [2:0] REQ_REMAP = 3'd4;
    localparam logic [2:0] REQ_READ  = 3'd5;

    localparam logic CFG_TR_ENABLE = 1'b0;
    localparam logic CFG_TR_INDEX  = 1'b1;

    typedef enum logic [1:0] {
        OP_MERGE,
        OP_REMAP,
        OP_READ
    } op_t;

    // Search token that walks down the cell row, one cell per cycle.
    typedef struct packed {
        logic               valid;
        op_t                op;
        logic [COLOR_W-1:0] data;      // key color, or read-back color
        logic               found;
        logic               appended;
        logic [IDX_W-1:0]   res_idx;   // hit index, or index to read
    } token_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

@@ sv/pmr_cell.sv @@
// One joined palette entry with its compare/append/read logic on the token path.
module pmr_cell #(
    parameter int unsigned CELL_INDEX = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmr_pkg::token_t        tok_in,
    input  logic [8:0]             count,
    output pmr_pkg::token_t        tok_out
);
    import pmr_pkg::*;

    logic [COLOR_W-1:0] entry_reg;
    token_t             tok_reg;
    token_t             tok_next;
    logic               write_en;
    logic               in_use;

    always_comb
    begin
        tok_next = tok_in;
        write_en = 1'b0;
        in_use   = (COUNT_W'(CELL_INDEX) < count);
        if (tok_in.valid)
        begin
            case (tok_in.op)
                OP_MERGE:
                begin
                    if (!tok_in.found && !tok_in.appended)
                    begin
                        if (in_use && entry_reg == tok_in.data)
                        begin
                            tok_next.found   = 1'b1;
                            tok_next.res_idx = IDX_W'(CELL_INDEX);
                        end
                        else if (count == COUNT_W'(CELL_INDEX))
                        begin
                            write_en          = 1'b1;
                            tok_next.appended = 1'b1;
                            tok_next.res_idx  = IDX_W'(CELL_INDEX);
                        end
                    end
                end
                OP_REMAP:
                begin
                    if (!tok_in.found && in_use && entry_reg == tok_in.data)
                    begin
                        tok_next.found   = 1'b1;
                        tok_next.res_idx = IDX_W'(CELL_INDEX);
                    end
                end
                OP_READ:
                begin
                    if (in_use && tok_in.res_idx == IDX_W'(CELL_INDEX))
                    begin
                        tok_next.found = 1'b1;
                        tok_next.data  = entry_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
            entry_reg <= tok_in.data;
    end

    assign tok_out = tok_reg;

endmodule

@@ sv/pmr_chain.sv @@
// Row of palette cells for entries 1 and up; token enters at entry 1.
module pmr_chain #(
    parameter int unsigned PALETTE_ENTRIES = pmr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pmr_pkg::token_t        tok_in,
    input  logic [8:0]             count,
    output pmr_pkg::token_t        tok_out
);
    import pmr_pkg::*;

    token_t link [0:PALETTE_ENTRIES-1];

    assign link[0] = tok_in;

    for (genvar g = 1; g < PALETTE_ENTRIES; g++)
    begin : g_cell
        pmr_cell #(
            .CELL_INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g-1]),
            .count   (count),
            .tok_out (link[g])
        );
    end

    assign tok_out = link[PALETTE_ENTRIES-1];

endmodule

@@ sv/palette_merge_and_remap.sv @@
// Top level of the palette merge and remap block: control, memories and result register.
// Joined palette builder and pixel remapper. Entry 0 of the joined palette is fixed
// magenta (transparency); entries 1..PALETTE_ENTRIES-1 live in a row of cells, and every
// merge, read of joined entry 1 or up and non-magenta cache-missing remap sends one search
// token down that row, one cell per clock. Clear, load, start-image, transparent and
// unknown requests, and a read of entry 0, go straight to the done state; a remap that
// hits the per-index cache (or maps to magenta) first passes the look state, which waits
// for the registered source/cache memory read. One request is in flight at a time;
// the result register lets a new request be taken while the previous result waits.
module palette_merge_and_remap #(
    parameter int unsigned PALETTE_ENTRIES = pmr_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // request beat
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [7:0]  index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    // result beat
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_index,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic        was_found,
    output logic [8:0]  color_count,
    output logic        overflowed,
    output logic        no_match
);
    import pmr_pkg::*;

    localparam int unsigned CACHE_DEPTH = 1 << IDX_W;

    state_t             state_reg, state_next;
    logic [2:0]         req_reg, req_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic               tr_en_reg;
    logic [IDX_W-1:0]   tr_idx_reg;
    logic [CACHE_DEPTH-1:0] cache_valid_reg;

    // pending result
    logic [IDX_W-1:0]   res_index_reg, res_index_next;
    logic [COLOR_W-1:0] res_color_reg, res_color_next;
    logic               res_found_reg, res_found_next;
    logic               res_nomatch_reg, res_nomatch_next;

    // result register
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_found_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_ovf_reg;
    logic               out_nomatch_reg;
    logic               out_load;

    // source palette and remap cache targets
    logic [COLOR_W-1:0] src_mem [0:CACHE_DEPTH-1];
    logic [IDX_W-1:0]   tgt_mem [0:CACHE_DEPTH-1];
    logic [COLOR_W-1:0] src_rd_reg;
    logic [IDX_W-1:0]   tgt_rd_reg;
    logic               tgt_we;
    logic [IDX_W-1:0]   tgt_wdata;
    logic               cache_set;
    logic               cache_clear;

    token_t             tok_inject;
    token_t             tok_end;
    logic               in_accept;
    logic [COLOR_W-1:0] in_color;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_color  = {red, green, blue};

    pmr_chain #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .tok_in  (tok_inject),
        .count   (count_reg),
        .tok_out (tok_end)
    );

    // Next state, request decode and result assembly
    always_comb
    begin
        state_next       = state_reg;
        req_next         = req_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        ovf_next         = ovf_reg;
        res_index_next   = res_index_reg;
        res_color_next   = res_color_reg;
        res_found_next   = res_found_reg;
        res_nomatch_next = res_nomatch_reg;
        tok_inject       = '0;
        tgt_we           = 1'b0;
        tgt_wdata        = '0;
        cache_set        = 1'b0;
        cache_clear      = 1'b0;
        out_load         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next         = req_type;
                    idx_next         = index;
                    res_index_next   = '0;
                    res_color_next   = '0;
                    res_found_next   = 1'b0;
                    res_nomatch_next = 1'b0;
                    state_next       = ST_DONE;
                    case (req_type)
                        REQ_CLEAR:
                        begin
                            count_next  = COUNT_W'(1);
                            ovf_next    = 1'b0;
                            cache_clear = 1'b1;
                        end
                        REQ_START:
                            cache_clear = 1'b1;
                        REQ_MERGE:
                        begin
                            tok_inject.valid = 1'b1;
                            tok_inject.op    = OP_MERGE;
                            tok_inject.data  = in_color;
                            state_next       = ST_SEARCH;
                        end
                        REQ_REMAP:
                        begin
                            if (!(tr_en_reg && index == tr_idx_reg))
                                state_next = ST_LOOK;
                        end
                        REQ_READ:
                        begin
                            res_index_next = index;
                            if (index == '0)
                                res_color_next = MAGENTA;
                            else
                            begin
                                tok_inject.valid   = 1'b1;
                                tok_inject.op      = OP_READ;
                                tok_inject.res_idx = index;
                                state_next         = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (cache_valid_reg[idx_reg])
                begin
                    res_index_next = tgt_rd_reg;
                    state_next     = ST_DONE;
                end
                else if (src_rd_reg == MAGENTA)
                begin
                    // entry 0 is the first match
                    tgt_we     = 1'b1;
                    cache_set  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    tok_inject.valid = 1'b1;
                    tok_inject.op    = OP_REMAP;
                    tok_inject.data  = src_rd_reg;
                    state_next       = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (tok_end.valid)
                begin
                    state_next = ST_DONE;
                    case (req_reg)
                        REQ_MERGE:
                        begin
                            if (tok_end.found)
                            begin
                                res_index_next = tok_end.res_idx;
                                res_found_next = 1'b1;
                            end
                            else if (tok_end.appended)
                            begin
                                res_index_next = tok_end.res_idx;
                                count_next     = count_reg + COUNT_W'(1);
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        REQ_REMAP:
                        begin
                            if (tok_end.found)
                            begin
                                res_index_next = tok_end.res_idx;
                                tgt_we         = 1'b1;
                                tgt_wdata      = tok_end.res_idx;
                                cache_set      = 1'b1;
                            end
                            else
                                res_nomatch_next = 1'b1;
                        end
                        REQ_READ:
                        begin
                            if (tok_end.found)
                                res_color_next = tok_end.data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= COUNT_W'(1);
            ovf_reg         <= 1'b0;
            tr_en_reg       <= 1'b0;
            tr_idx_reg      <= '0;
            cache_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TR_ENABLE: tr_en_reg  <= cfg_data[0];
                    CFG_TR_INDEX:  tr_idx_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (cache_clear)
                cache_valid_reg <= '0;
            else if (cache_set)
                cache_valid_reg[idx_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        idx_reg         <= idx_next;
        res_index_reg   <= res_index_next;
        res_color_reg   <= res_color_next;
        res_found_reg   <= res_found_next;
        res_nomatch_reg <= res_nomatch_next;
        if (out_load)
        begin
            out_index_reg   <= res_index_reg;
            out_color_reg   <= res_color_reg;
            out_found_reg   <= res_found_reg;
            out_count_reg   <= count_reg;
            out_ovf_reg     <= ovf_reg;
            out_nomatch_reg <= res_nomatch_reg;
        end
    end

    // memories: source palette write on load, registered reads on accept
    always_ff @(posedge clk)
    begin
        if (in_accept && req_type == REQ_LOAD)
            src_mem[index] <= in_color;
        if (in_accept)
        begin
            src_rd_reg <= src_mem[index];
            tgt_rd_reg <= tgt_mem[index];
        end
        if (tgt_we)
            tgt_mem[idx_reg] <= tgt_wdata;
    end

    assign out_valid   = out_valid_reg;
    assign out_index   = out_index_reg;
    assign out_red     = out_color_reg[23:16];
    assign out_green   = out_color_reg[15:8];
    assign out_blue    = out_color_reg[7:0];
    assign was_found   = out_found_reg;
    assign color_count = out_count_reg;
    assign overflowed  = out_ovf_reg;
    assign no_match    = out_nomatch_reg;

`ifndef SYNTH
    a_no_stray_token: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SEARCH) |-> !tok_end.valid)
        else $error("search token left the row outside a search");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= COUNT_W'(1)) && (count_reg <= COUNT_W'(PALETTE_ENTRIES)))
        else $error("joined count out of range");

    a_merge_searches: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && req_type == REQ_MERGE) |=> (state_reg == ST_SEARCH))
        else $error("merge did not start a search");

    a_cache_set_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cache_set |-> (req_reg == REQ_REMAP))
        else $error("cache written outside a remap");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for the palette merge and remap block: directed and random request beats.
`timescale 1ns / 100ps

module tb;
    import pmr_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type = 3'd0;
    logic [7:0]  index = 8'd0;
    logic [7:0]  red = 8'd0;
    logic [7:0]  green = 8'd0;
    logic [7:0]  blue = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        was_found;
    logic [8:0]  color_count;
    logic        overflowed;
    logic        no_match;

    palette_merge_and_remap dut (.*);

    always #4 clk = ~clk;

    // One expected result beat.
    typedef struct {
        logic [7:0] idx;
        logic [7:0] r, g, b;
        logic       found;
        logic [8:0] count;
        logic       ovf;
        logic       nomatch;
    } answer_t;

    answer_t answers_due[$];

    // Model state of the palette block.
    logic [23:0] pal_model [256];
    logic [23:0] src_model [256];
    logic        src_loaded [256];
    logic        hit_valid [256];
    logic [7:0]  hit_target [256];
    int unsigned pal_used;
    logic        ovf_model;
    logic        tr_en_model;
    logic [7:0]  tr_idx_model;

    int unsigned errors = 0;
    int unsigned beats_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    int unsigned merges = 0, remaps = 0, misses = 0, fulls = 0;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned TAIL_CYCLES = 300;

    function automatic void model_clear();
        pal_model[0] = MAGENTA;
        pal_used = 1;
        ovf_model = 1'b0;
        foreach (hit_valid[i]) hit_valid[i] = 1'b0;
    endfunction

    // Apply one request to the model and produce its answer.
    function automatic answer_t predict_beat(logic [2:0] rq, logic [7:0] ix,
                                             logic [23:0] col);
        answer_t a;
        logic [23:0] want;
        a = '{idx: 8'd0, r: 8'd0, g: 8'd0, b: 8'd0, found: 1'b0, count: 9'd0,
              ovf: 1'b0, nomatch: 1'b0};
        case (rq)
            REQ_CLEAR: model_clear();
            REQ_MERGE:
            begin
                merges++;
                for (int k = 1; k < pal_used; k++)
                    if (!a.found && pal_model[k] == col)
                    begin
                        a.found = 1'b1;
                        a.idx = k[7:0];
                    end
                if (!a.found)
                begin
                    if (pal_used < PALETTE_ENTRIES_DEF)
                    begin
                        pal_model[pal_used] = col;
                        a.idx = pal_used[7:0];
                        pal_used++;
                    end
                    else
                    begin
                        ovf_model = 1'b1;
                        fulls++;
                    end
                end
            end
            REQ_LOAD:
            begin
                src_model[ix] = col;
                src_loaded[ix] = 1'b1;
            end
            REQ_START: foreach (hit_valid[i]) hit_valid[i] = 1'b0;
            REQ_REMAP:
            begin
                remaps++;
                if (tr_en_model && ix == tr_idx_model)
                    a.idx = 8'd0;
                else if (hit_valid[ix])
                    a.idx = hit_target[ix];
                else
                begin
                    logic hit;
                    hit = 1'b0;
                    want = src_model[ix];
                    for (int k = 0; k < pal_used; k++)
                        if (!hit && pal_model[k] == want)
                        begin
                            hit = 1'b1;
                            a.idx = k[7:0];
                        end
                    if (hit)
                    begin
                        hit_valid[ix] = 1'b1;
                        hit_target[ix] = a.idx;
                    end
                    else
                    begin
                        a.nomatch = 1'b1;
                        misses++;
                    end
                end
            end
            REQ_READ:
            begin
                a.idx = ix;
                if (ix < pal_used)
                    {a.r, a.g, a.b} = pal_model[ix];
            end
            default: ;
        endcase
        a.count = pal_used[8:0];
        a.ovf = ovf_model;
        return a;
    endfunction

    // Short random gap, occasionally long.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one request beat and record its expected answer.
    task automatic send_req(logic [2:0] rq, logic [7:0] ix, logic [23:0] col);
        answers_due.push_back(predict_beat(rq, ix, col));
        req_type <= rq;
        index    <= ix;
        {red, green, blue} <= col;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        begin
            int unsigned g;
            g = gap_len();
            if (g != 0)
            begin
                in_valid <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    endtask

    // Wait for all answers, then let the block settle before touching registers.
    task automatic drain();
        @(posedge clk);
        in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_TR_ENABLE) tr_en_model = val[0];
        else tr_idx_model = val;
    endtask

    // Pick a source index, mostly ones already loaded.
    function automatic logic [7:0] loaded_idx();
        logic [7:0] ix;
        for (int t = 0; t < 50; t++)
        begin
            ix = 8'($urandom_range(0, 255));
            if (src_loaded[ix]) return ix;
        end
        return 8'd0;
    endfunction

    // Receiver: random stalls, compare every field against the oldest answer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                answer_t e;
                beats_seen++;
                if (answers_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected (idx %0d)", $time,
                             out_index);
                end
                else
                begin
                    e = answers_due.pop_front();
                    if (out_index !== e.idx || out_red !== e.r || out_green !== e.g ||
                        out_blue !== e.b || was_found !== e.found ||
                        color_count !== e.count || overflowed !== e.ovf ||
                        no_match !== e.nomatch)
                    begin
                        errors++;
                        $display("%0t: mismatch exp idx=%0d rgb=%h%h%h fnd=%b cnt=%0d ovf=%b nm=%b",
                                 $time, e.idx, e.r, e.g, e.b, e.found, e.count, e.ovf,
                                 e.nomatch);
                        $display("%0t:          act idx=%0d rgb=%h%h%h fnd=%b cnt=%0d ovf=%b nm=%b",
                                 $time, out_index, out_red, out_green, out_blue, was_found,
                                 color_count, overflowed, no_match);
                    end
                end
            end
            // mostly short stalls, now and then a long one
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                stall_left = $urandom_range(10, 40);
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 :
                             ($urandom_range(0, 9) == 0);
        end
    end

    // Watchdog on cycles.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_directed();
        // Read entry 0 and one beyond count, unknown types, magenta merge.
        send_req(REQ_READ, 8'd0, 24'd0);
        send_req(REQ_READ, 8'd255, 24'hFFFFFF);
        send_req(3'd6, 8'hFF, 24'hFFFFFF);
        send_req(3'd7, 8'h00, 24'h000000);
        send_req(REQ_MERGE, 8'd0, MAGENTA);
        send_req(REQ_MERGE, 8'd0, 24'h000000);
        send_req(REQ_MERGE, 8'd0, 24'hFFFFFF);
        send_req(REQ_MERGE, 8'd0, 24'h000000);
        send_req(REQ_READ, 8'd2, 24'd0);
        send_req(REQ_LOAD, 8'd0, 24'hFFFFFF);
        send_req(REQ_LOAD, 8'd255, 24'h123456);
        send_req(REQ_LOAD, 8'd1, MAGENTA);
        send_req(REQ_START, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd255, 24'd0);
        send_req(REQ_REMAP, 8'd1, 24'd0);
        // Load after start: cached result is kept.
        send_req(REQ_LOAD, 8'd0, 24'h000000);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        send_req(REQ_CLEAR, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        drain();
    endtask

    task automatic test_transparency();
        write_reg(CFG_TR_INDEX, 8'd255);
        write_reg(CFG_TR_ENABLE, 8'd1);
        send_req(REQ_REMAP, 8'd255, 24'd0);
        send_req(REQ_MERGE, 8'd0, 24'h123456);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        drain();
        write_reg(CFG_TR_INDEX, 8'd0);
        send_req(REQ_REMAP, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd255, 24'd0);
        drain();
    endtask

    // Fill the palette past its limit so the overflow path is taken.
    task automatic test_overflow();
        send_req(REQ_CLEAR, 8'd0, 24'd0);
        for (int k = 0; k < 258; k++)
            send_req(REQ_MERGE, 8'd0, {8'hA5, 16'(k)});
        send_req(REQ_MERGE, 8'd0, {8'hA5, 16'd7});
        send_req(REQ_READ, 8'd255, 24'd0);
        send_req(REQ_LOAD, 8'd3, {8'hA5, 16'd254});
        send_req(REQ_START, 8'd0, 24'd0);
        send_req(REQ_REMAP, 8'd3, 24'd0);
        drain();
    endtask

    // Image-like flows with a small color set: load, start, many remaps.
    task automatic test_random(int unsigned phases, int unsigned per_phase);
        logic [23:0] colors [8];
        int unsigned p;
        logic [7:0] ix;
        for (int ph = 0; ph < phases; ph++)
        begin
            write_reg(CFG_TR_ENABLE, 8'($urandom_range(0, 1)));
            write_reg(CFG_TR_INDEX, 8'($urandom_range(0, 255)));
            foreach (colors[i]) colors[i] = 24'($urandom);
            if ($urandom_range(0, 3) == 0) send_req(REQ_CLEAR, 8'd0, 24'd0);
            for (int n = 0; n < per_phase; n++)
            begin
                p = $urandom_range(0, 99);
                ix = 8'($urandom_range(0, 255));
                if (p < 15)
                    send_req(REQ_MERGE, ix, ($urandom_range(0, 9) == 0) ?
                             24'($urandom) : colors[$urandom_range(0, 7)]);
                else if (p < 30)
                    send_req(REQ_LOAD, ix, ($urandom_range(0, 9) == 0) ?
                             24'($urandom) : colors[$urandom_range(0, 7)]);
                else if (p < 34)
                    send_req(REQ_START, ix, 24'($urandom));
                else if (p < 80)
                    send_req(REQ_REMAP, loaded_idx(), 24'($urandom));
                else if (p < 94)
                    send_req(REQ_READ, ($urandom_range(0, 1) != 0) ?
                             8'($urandom_range(0, 15)) : ix, 24'($urandom));
                else if (p < 97)
                    send_req(3'($urandom_range(6, 7)), ix, 24'($urandom));
                else
                    send_req(REQ_CLEAR, ix, 24'($urandom));
            end
            drain();
        end
    endtask

    initial
    begin
        foreach (src_loaded[i])
        begin
            src_loaded[i] = 1'b0;
            src_model[i] = 24'd0;
            pal_model[i] = 24'd0;
            hit_target[i] = 8'd0;
        end
        model_clear();
        tr_en_model = 1'b0;
        tr_idx_model = 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_transparency();
        test_overflow();
        test_random(10, 65);

        $display("sent %0d beats, checked %0d: %0d merges, %0d remaps", beats_sent,
                 beats_seen, merges, remaps);
        $display("remap misses %0d, full-palette merges %0d, errors %0d", misses, fulls,
                 errors);
        if (errors == 0 && answers_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
